/* src/sscl_pkg.sv */
// Shared constants, types and helpers of the screen stack clip engine.
`default_nettype none
package sscl_pkg;

   localparam int MAX_LAYERS_DEF = 8;
   localparam int CRD_W          = 20;
   localparam int CSR_IDX_W      = 2;
   localparam int CSR_DATA_W     = 14;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_SCREEN_WIDTH  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SCREEN_HEIGHT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_LAYER_COUNT   = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_DRAG_MARGIN   = 2'd3;

   localparam logic [13:0] SCREEN_WIDTH_RST  = 14'd640;
   localparam logic [13:0] SCREEN_HEIGHT_RST = 14'd480;
   localparam logic [7:0]  DRAG_MARGIN_RST   = 8'd14;

   // request codes
   localparam logic [1:0] REQ_GEOMETRY       = 2'd0;
   localparam logic [1:0] REQ_LAYER_DAMAGE   = 2'd1;
   localparam logic [1:0] REQ_DISPLAY_DAMAGE = 2'd2;
   localparam logic [1:0] REQ_VALIDATE       = 2'd3;

   // result kinds
   localparam logic [1:0] KIND_REFRESH = 2'd0;
   localparam logic [1:0] KIND_CLEAR   = 2'd1;
   localparam logic [1:0] KIND_CLAMP   = 2'd2;

   typedef logic signed [CRD_W-1:0] crd_type;

   localparam crd_type SAT_HI = crd_type'(32767);
   localparam crd_type SAT_LO = crd_type'(-32768);

   typedef enum logic [1:0] {PTR_HOLD, PTR_ZERO, PTR_LAY, PTR_INC} ptr_op_type;
   typedef enum logic [1:0] {RECT_LAYER, RECT_LDMG, RECT_DDMG} rect_sel_type;

   // controller to datapath
   typedef struct packed {
      logic         capture;
      ptr_op_type   ptr_op;
      logic         store_geo;
      logic         init_scan;
      logic         rect_load;
      rect_sel_type rect_sel;
      logic         recomp;
      logic         emit_clip;
      logic         emit_bg;
      logic         emit_val;
      logic         flush;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic [1:0] req_type;
      logic       on_stack;
      logic       vis_ptr;
      logic       ptr_end;
      logic       cnt_zero;
      logic       stall;
   } status_type;

   typedef struct packed {
      logic [1:0]         kind;
      logic [2:0]         out_layer;
      logic signed [15:0] min_x;
      logic signed [15:0] min_y;
      logic signed [15:0] max_x;
      logic signed [15:0] max_y;
      logic signed [15:0] clamped_x;
      logic signed [15:0] clamped_y;
      logic               last;
   } res_type;

   // saturate a coordinate to 16 bits signed
   function automatic logic signed [15:0] sat16(input crd_type v);
      logic signed [15:0] r;
      if (v > SAT_HI) r = 16'sh7FFF;
      else if (v < SAT_LO) r = 16'sh8000;
      else r = v[15:0];
      return r;
   endfunction

endpackage
`default_nettype wire

/* src/sscl_if.sv */
// Request and result channel interfaces of the screen stack clip engine.
`default_nettype none
interface sscl_req_if;
   logic               valid;
   logic               ready;
   logic [1:0]         req_type;
   logic [2:0]         layer;
   logic signed [15:0] pos_x;
   logic signed [15:0] pos_y;
   logic [13:0]        size_w;
   logic [13:0]        size_h;

   modport source(output valid, req_type, layer, pos_x, pos_y, size_w, size_h,
                  input ready);
   modport sink(input valid, req_type, layer, pos_x, pos_y, size_w, size_h,
                output ready);
endinterface

interface sscl_rsp_if;
   logic               valid;
   logic               ready;
   logic [1:0]         kind;
   logic [2:0]         out_layer;
   logic signed [15:0] min_x;
   logic signed [15:0] min_y;
   logic signed [15:0] max_x;
   logic signed [15:0] max_y;
   logic signed [15:0] clamped_x;
   logic signed [15:0] clamped_y;
   logic               last;

   modport source(output valid, kind, out_layer, min_x, min_y, max_x, max_y,
                  clamped_x, clamped_y, last, input ready);
   modport sink(input valid, kind, out_layer, min_x, min_y, max_x, max_y,
                clamped_x, clamped_y, last, output ready);
endinterface
`default_nettype wire

/* src/sscl_ctrl.sv */
// Sequencer of the screen stack clip engine: walks each request through its steps.
`default_nettype none
module sscl_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  sscl_pkg::status_type sts,
   output sscl_pkg::cmd_type    cmd
);
   import sscl_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE, ST_DISPATCH, ST_G_STORE, ST_G_RECT, ST_G_CLIP, ST_G_BG,
      ST_L_RECT, ST_L_CLIP, ST_D_RECT, ST_D_CLIP, ST_V_EMIT, ST_DONE
   } state_type;

   state_type state_ff, state_in;

   assign req_ready = (state_ff == ST_IDLE);

   // next state and step commands
   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ST_DISPATCH;
            end
         end
         ST_DISPATCH: begin
            cmd.ptr_op = PTR_LAY;
            case (sts.req_type)
               REQ_GEOMETRY:       state_in = sts.on_stack ? ST_G_STORE : ST_DONE;
               REQ_LAYER_DAMAGE:   state_in = sts.on_stack ? ST_L_RECT : ST_DONE;
               REQ_DISPLAY_DAMAGE: begin
                  cmd.ptr_op = PTR_ZERO;
                  state_in   = ST_D_RECT;
               end
               default:            state_in = ST_V_EMIT;
            endcase
         end
         ST_G_STORE: begin
            cmd.store_geo = 1'b1;
            cmd.init_scan = 1'b1;
            cmd.ptr_op    = PTR_ZERO;
            state_in      = ST_G_RECT;
         end
         ST_G_RECT: begin
            cmd.rect_load = 1'b1;
            cmd.rect_sel  = RECT_LAYER;
            cmd.recomp    = 1'b1;
            state_in      = ST_G_CLIP;
         end
         ST_G_CLIP: begin
            if (!sts.stall) begin
               cmd.emit_clip = sts.vis_ptr;
               if (sts.ptr_end) state_in = ST_G_BG;
               else begin
                  cmd.ptr_op = PTR_INC;
                  state_in   = ST_G_RECT;
               end
            end
         end
         ST_G_BG: begin
            if (!sts.stall) begin
               cmd.emit_bg = 1'b1;
               state_in    = ST_DONE;
            end
         end
         ST_L_RECT: begin
            if (sts.vis_ptr) begin
               cmd.rect_load = 1'b1;
               cmd.rect_sel  = RECT_LDMG;
               state_in      = ST_L_CLIP;
            end else state_in = ST_DONE;
         end
         ST_L_CLIP: begin
            if (!sts.stall) begin
               cmd.emit_clip = 1'b1;
               state_in      = ST_DONE;
            end
         end
         ST_D_RECT: begin
            cmd.rect_load = 1'b1;
            cmd.rect_sel  = RECT_DDMG;
            state_in      = sts.cnt_zero ? ST_DONE : ST_D_CLIP;
         end
         ST_D_CLIP: begin
            if (!sts.stall) begin
               cmd.emit_clip = sts.vis_ptr;
               if (sts.ptr_end) state_in = ST_DONE;
               else cmd.ptr_op = PTR_INC;
            end
         end
         ST_V_EMIT: begin
            if (!sts.stall) begin
               cmd.emit_val = 1'b1;
               state_in     = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!sts.stall) begin
               cmd.flush = 1'b1;
               state_in  = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // state register
   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else state_ff <= state_in;
   end

endmodule
`default_nettype wire

/* src/sscl_dp.sv */
// Datapath of the screen stack clip engine: layer store, visible bands, clipping, results.
`default_nettype none
module sscl_dp #(
   parameter int MAX_LAYERS = sscl_pkg::MAX_LAYERS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_we,
   input  logic [sscl_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [sscl_pkg::CSR_DATA_W-1:0]   csr_wdata,
   input  logic [1:0]                        req_type,
   input  logic [2:0]                        layer,
   input  logic signed [15:0]                pos_x,
   input  logic signed [15:0]                pos_y,
   input  logic [13:0]                       size_w,
   input  logic [13:0]                       size_h,
   input  sscl_pkg::cmd_type                 cmd,
   output sscl_pkg::status_type              sts,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output sscl_pkg::res_type                 rsp_data
);
   import sscl_pkg::*;

   localparam int IDX_W = (MAX_LAYERS > 1) ? $clog2(MAX_LAYERS) : 1;

   // configuration
   logic [13:0] sw_ff, sh_ff;
   logic [3:0]  lc_ff;
   logic [7:0]  margin_ff;

   // captured request
   logic [1:0]         typ_ff;
   logic [2:0]         lay_ff;
   logic signed [15:0] px_ff, py_ff;
   logic [13:0]        w_ff, h_ff;

   // layer store and visible bands
   logic signed [15:0] left_ff [MAX_LAYERS];
   logic signed [15:0] top_ff  [MAX_LAYERS];
   logic [13:0]        wide_ff [MAX_LAYERS];
   logic [13:0]        tall_ff [MAX_LAYERS];
   logic               vis_ff  [MAX_LAYERS];
   logic signed [15:0] vtop_ff [MAX_LAYERS];
   logic signed [15:0] vbot_ff [MAX_LAYERS];

   logic [IDX_W-1:0] ptr_ff, ptr_in;
   crd_type          last_ff, first_ff;
   logic [13:0]      revealed_ff;
   crd_type          rx0_ff, ry0_ff, rx1_ff, ry1_ff;

   res_type pend_ff, out_ff, cand, load_res;
   logic    pend_valid_ff, out_valid_ff;

   logic [5:0] lay6, lc6, max6, cnt6, ptr6;
   logic       on_stack;

   crd_type sw_s, sh_s, wmax;
   crd_type cur_left, cur_top, cur_wide, cur_tall, vt, vb;
   crd_type offx, offy, addx, addy, sizew, sizeh;
   crd_type mn;
   logic    rc_vis;
   crd_type cx0, cx1, cy0, cy1;
   logic    clip_ok;
   crd_type rev_s;
   logic    bg_ok;
   crd_type limx, limy, drag, valx, valy;
   logic    cand_valid, load_out, stall;

   // stack bounds
   always_comb begin
      lay6     = {3'b000, lay_ff};
      lc6      = {2'b00, lc_ff};
      max6     = 6'(MAX_LAYERS);
      cnt6     = (lc6 < max6) ? lc6 : max6;
      ptr6     = 6'(ptr_ff);
      on_stack = (lay6 < cnt6);
   end

   // selected layer entry
   always_comb begin
      sw_s     = crd_type'(sw_ff);
      sh_s     = crd_type'(sh_ff);
      wmax     = sw_s - crd_type'(1);
      cur_left = crd_type'(left_ff[ptr_ff]);
      cur_top  = crd_type'(top_ff[ptr_ff]);
      cur_wide = crd_type'(wide_ff[ptr_ff]);
      cur_tall = crd_type'(tall_ff[ptr_ff]);
      vt       = crd_type'(vtop_ff[ptr_ff]);
      vb       = crd_type'(vbot_ff[ptr_ff]);
   end

   // rectangle in screen coordinates
   always_comb begin
      offx  = (cmd.rect_sel == RECT_LAYER) ? crd_type'(0) : crd_type'(px_ff);
      offy  = (cmd.rect_sel == RECT_LAYER) ? crd_type'(0) : crd_type'(py_ff);
      addx  = (cmd.rect_sel == RECT_DDMG) ? crd_type'(0) : cur_left;
      addy  = (cmd.rect_sel == RECT_DDMG) ? crd_type'(0) : cur_top;
      sizew = (cmd.rect_sel == RECT_LAYER) ? cur_wide : crd_type'(w_ff);
      sizeh = (cmd.rect_sel == RECT_LAYER) ? cur_tall : crd_type'(h_ff);
   end

   // visible band of the layer under the pointer
   always_comb begin
      mn     = (cur_top < 0) ? crd_type'(0) : cur_top;
      rc_vis = (sw_ff != 14'd0) && (mn <= last_ff);
   end

   // clip against screen width and visible band
   always_comb begin
      cx0     = (rx0_ff < 0) ? crd_type'(0) : rx0_ff;
      cx1     = (rx1_ff > wmax) ? wmax : rx1_ff;
      cy0     = (ry0_ff < vt) ? vt : ry0_ff;
      cy1     = (ry1_ff > vb) ? vb : ry1_ff;
      clip_ok = (cx0 <= cx1) && (cy0 <= cy1);
   end

   // background clear and position check
   always_comb begin
      rev_s = crd_type'(revealed_ff);
      bg_ok = (first_ff > rev_s);
      limx  = sw_s - cur_wide;
      limy  = sh_s - cur_tall;
      drag  = sh_s - crd_type'(1) - crd_type'(margin_ff);
      valx  = crd_type'(px_ff);
      valy  = crd_type'(py_ff);
      if (on_stack) begin
         if (valx > 0) valx = crd_type'(0);
         if (valx < limx) valx = limx;
         if (valy > drag) valy = drag;
         if (valy < limy) valy = limy;
      end
   end

   // candidate result
   always_comb begin
      cand       = '0;
      cand_valid = 1'b0;
      if (cmd.emit_val) begin
         cand.kind      = KIND_CLAMP;
         cand.out_layer = lay_ff;
         cand.clamped_x = sat16(valx);
         cand.clamped_y = sat16(valy);
         cand_valid     = 1'b1;
      end else if (cmd.emit_bg) begin
         cand.kind  = KIND_CLEAR;
         cand.min_y = sat16(rev_s);
         cand.max_x = sat16(wmax);
         cand.max_y = sat16(first_ff - crd_type'(1));
         cand_valid = bg_ok;
      end else begin
         cand.kind      = KIND_REFRESH;
         cand.out_layer = ptr6[2:0];
         cand.min_x     = sat16(cx0 - cur_left);
         cand.min_y     = sat16(cy0 - cur_top);
         cand.max_x     = sat16(cx1 - cur_left);
         cand.max_y     = sat16(cy1 - cur_top);
         cand_valid     = cmd.emit_clip && clip_ok;
      end
   end

   // one result is held back so that the final one can be marked
   assign stall    = pend_valid_ff && out_valid_ff && !rsp_ready;
   assign load_out = (cand_valid || cmd.flush) && pend_valid_ff;

   // held result as it moves to the output, marked when the request ends
   always_comb begin
      load_res      = pend_ff;
      load_res.last = cmd.flush;
   end

   always_comb begin
      case (cmd.ptr_op)
         PTR_ZERO: ptr_in = '0;
         PTR_LAY:  ptr_in = lay6[IDX_W-1:0];
         PTR_INC:  ptr_in = ptr_ff + IDX_W'(1);
         default:  ptr_in = ptr_ff;
      endcase
   end

   assign sts.req_type = typ_ff;
   assign sts.on_stack = on_stack;
   assign sts.vis_ptr  = vis_ff[ptr_ff];
   assign sts.ptr_end  = ((ptr6 + 6'd1) >= cnt6);
   assign sts.cnt_zero = (cnt6 == 6'd0);
   assign sts.stall    = stall;

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         sw_ff     <= SCREEN_WIDTH_RST;
         sh_ff     <= SCREEN_HEIGHT_RST;
         lc_ff     <= '0;
         margin_ff <= DRAG_MARGIN_RST;
      end else if (csr_we) begin
         case (csr_index)
            CSR_SCREEN_WIDTH:  sw_ff     <= csr_wdata;
            CSR_SCREEN_HEIGHT: sh_ff     <= csr_wdata;
            CSR_LAYER_COUNT:   lc_ff     <= csr_wdata[3:0];
            CSR_DRAG_MARGIN:   margin_ff <= csr_wdata[7:0];
            default:           sw_ff     <= sw_ff;
         endcase
      end
   end

   // request capture and working registers
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         typ_ff <= req_type;
         lay_ff <= layer;
         px_ff  <= pos_x;
         py_ff  <= pos_y;
         w_ff   <= size_w;
         h_ff   <= size_h;
      end
      if (cmd.rect_load) begin
         rx0_ff <= offx + addx;
         ry0_ff <= offy + addy;
         rx1_ff <= offx + addx + sizew - crd_type'(1);
         ry1_ff <= offy + addy + sizeh - crd_type'(1);
      end
      ptr_ff <= ptr_in;
      if (cmd.init_scan) begin
         last_ff  <= sh_s - crd_type'(1);
         first_ff <= sh_s - crd_type'(1);
      end else if (cmd.recomp && rc_vis) begin
         last_ff <= mn - crd_type'(1);
         if (mn < first_ff) first_ff <= mn;
      end
   end

   // layer store, bands and revealed line
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < MAX_LAYERS; i++) begin
            left_ff[i] <= '0;
            top_ff[i]  <= '0;
            wide_ff[i] <= '0;
            tall_ff[i] <= '0;
            vis_ff[i]  <= 1'b0;
            vtop_ff[i] <= '0;
            vbot_ff[i] <= '0;
         end
         revealed_ff <= '0;
      end else begin
         if (csr_we && csr_index == CSR_LAYER_COUNT) begin
            for (int i = 0; i < MAX_LAYERS; i++) vis_ff[i] <= 1'b0;
         end
         if (cmd.store_geo) begin
            left_ff[ptr_ff] <= px_ff;
            top_ff[ptr_ff]  <= py_ff;
            wide_ff[ptr_ff] <= w_ff;
            tall_ff[ptr_ff] <= h_ff;
         end
         if (cmd.recomp) begin
            vtop_ff[ptr_ff] <= mn[15:0];
            vbot_ff[ptr_ff] <= last_ff[15:0];
            vis_ff[ptr_ff]  <= rc_vis;
         end
         if (cmd.emit_bg) revealed_ff <= (first_ff < 0) ? 14'd0 : first_ff[13:0];
      end
   end

   // held result and output register
   always_ff @(posedge clock) begin
      if (reset) begin
         pend_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         if (load_out) out_valid_ff <= 1'b1;
         else if (rsp_ready) out_valid_ff <= 1'b0;
         if (cand_valid) pend_valid_ff <= 1'b1;
         else if (cmd.flush) pend_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load_out) out_ff <= load_res;
      if (cand_valid) pend_ff <= cand;
   end

endmodule
`default_nettype wire

/* src/screen_stack_clip_engine_top.sv */
// Top level of the screen stack clip engine.
//
// Keeps up to MAX_LAYERS screen layers, front first, and turns geometry updates,
// layer damage, display damage and position checks into refresh rectangles,
// background clears and clamped offsets on the result channel, the final result
// of each request marked by last. One request is worked at a time. A geometry
// update walks the stack layer by layer, recomputing each layer's band and then
// clipping against it; a display damage also walks the stack, without the band
// step. A held-back result channel can stall either walk. Results pass through
// an output register, so a new request is taken while the last result still waits.
`default_nettype none
module screen_stack_clip_engine_top #(
   parameter int MAX_LAYERS = sscl_pkg::MAX_LAYERS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_we,
   input  logic [sscl_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [sscl_pkg::CSR_DATA_W-1:0] csr_wdata,
   sscl_req_if.sink                        req_ch,
   sscl_rsp_if.source                      rsp_ch
);
   import sscl_pkg::*;

   cmd_type    cmd;
   status_type sts;
   res_type    res;

   sscl_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   sscl_dp #(.MAX_LAYERS(MAX_LAYERS)) u_dp (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_type  (req_ch.req_type),
      .layer     (req_ch.layer),
      .pos_x     (req_ch.pos_x),
      .pos_y     (req_ch.pos_y),
      .size_w    (req_ch.size_w),
      .size_h    (req_ch.size_h),
      .cmd       (cmd),
      .sts       (sts),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .rsp_data  (res)
   );

   assign rsp_ch.kind      = res.kind;
   assign rsp_ch.out_layer = res.out_layer;
   assign rsp_ch.min_x     = res.min_x;
   assign rsp_ch.min_y     = res.min_y;
   assign rsp_ch.max_x     = res.max_x;
   assign rsp_ch.max_y     = res.max_y;
   assign rsp_ch.clamped_x = res.clamped_x;
   assign rsp_ch.clamped_y = res.clamped_y;
   assign rsp_ch.last      = res.last;

`ifndef SYNTH
   // nothing is held back once the engine is idle
   a_idle_no_held: assert property (@(posedge clock) disable iff (reset)
      req_ch.ready |-> !sts.stall)
      else $error("held result left over while idle");

   // at most one result step per cycle
   a_one_step: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.emit_clip, cmd.emit_bg, cmd.emit_val, cmd.flush}))
      else $error("conflicting result steps");

   // a taken request closes the input until it is done
   a_busy_after_take: assert property (@(posedge clock) disable iff (reset)
      cmd.capture |=> !req_ch.ready)
      else $error("request channel open while a request is in work");
`endif

endmodule
`default_nettype wire

/* bench/screen_stack_clip_engine_top_tb.sv */
// Self-checking testbench of the screen stack clip engine: predicted results against the result channel.
`default_nettype none
module screen_stack_clip_engine_top_tb;
   import sscl_pkg::*;

   logic                  clock;
   logic                  reset;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   sscl_req_if req_bus();
   sscl_rsp_if rsp_bus();

   screen_stack_clip_engine_top u_dut (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_ch    (req_bus),
      .rsp_ch    (rsp_bus)
   );

   // predictor copy of the registers and the layer stack
   int scr_w, scr_h, lay_cnt, margin;
   int lay_left[8], lay_top[8], lay_wide[8], lay_tall[8];
   bit lay_vis[8];
   int band_top[8], band_bot[8];
   int revealed;
   int step_results;

   res_type expect_q[$];
   int      errors;
   int      burst_left;
   bit      hold_req;
   int      hold_left;

   // clock
   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // generous end of run
   initial begin
      #400000;
      $display("FAIL screen_stack_clip_engine_top");
      $finish;
   end

   function automatic int clamp16(int v);
      if (v > 32767) return 32767;
      if (v < -32768) return -32768;
      return v;
   endfunction

   function automatic int stack_used();
      return (lay_cnt < 8) ? lay_cnt : 8;
   endfunction

   function automatic void push_result(logic [1:0] k, int ly, int x0, int y0, int x1, int y1,
                                       int cx, int cy);
      res_type r;
      r.kind      = k;
      r.out_layer = ly[2:0];
      r.min_x     = 16'(clamp16(x0));
      r.min_y     = 16'(clamp16(y0));
      r.max_x     = 16'(clamp16(x1));
      r.max_y     = 16'(clamp16(y1));
      r.clamped_x = 16'(clamp16(cx));
      r.clamped_y = 16'(clamp16(cy));
      r.last      = 1'b0;
      expect_q.push_back(r);
      step_results++;
   endfunction

   // clip a screen rectangle to a layer band, result in layer coordinates
   function automatic void clip_to_band(int i, int x0, int y0, int x1, int y1);
      if (x0 < 0) x0 = 0;
      if (x1 > scr_w - 1) x1 = scr_w - 1;
      if (y0 < band_top[i]) y0 = band_top[i];
      if (y1 > band_bot[i]) y1 = band_bot[i];
      if (x0 > x1 || y0 > y1) return;
      push_result(KIND_REFRESH, i, x0 - lay_left[i], y0 - lay_top[i],
                  x1 - lay_left[i], y1 - lay_top[i], 0, 0);
   endfunction

   // recompute bands, refresh every visible layer, clear revealed lines
   function automatic void redraw_stack();
      int cnt, line, first, mn;
      cnt  = stack_used();
      line = scr_h - 1;
      for (int i = 0; i < cnt; i++) begin
         mn          = (lay_top[i] > 0) ? lay_top[i] : 0;
         band_top[i] = mn;
         band_bot[i] = line;
         lay_vis[i]  = (scr_w >= 1) && (mn <= line);
         if (lay_vis[i]) line = mn - 1;
      end
      first = scr_h - 1;
      for (int i = 0; i < cnt; i++) begin
         if (lay_vis[i]) begin
            clip_to_band(i, lay_left[i], lay_top[i], lay_left[i] + lay_wide[i] - 1,
                         lay_top[i] + lay_tall[i] - 1);
            if (band_top[i] < first) first = band_top[i];
         end
      end
      if (first > revealed)
         push_result(KIND_CLEAR, 0, 0, revealed, scr_w - 1, first - 1, 0, 0);
      revealed = (first < 0) ? 0 : (first & 16'h3FFF);
   endfunction

   // expected results of one accepted request
   function automatic void predict_request(logic [1:0] rt, logic [2:0] ly,
                                           logic signed [15:0] px, logic signed [15:0] py,
                                           logic [13:0] w, logic [13:0] h);
      int  x, y, wi, hi, li, cx, cy, limx, limy, drag;
      bit  on;
      x  = px;
      y  = py;
      wi = w;
      hi = h;
      li = ly;
      on = li < stack_used();
      step_results = 0;
      case (rt)
         REQ_GEOMETRY: begin
            if (on) begin
               lay_left[li] = x;
               lay_top[li]  = y;
               lay_wide[li] = wi;
               lay_tall[li] = hi;
               redraw_stack();
            end
         end
         REQ_LAYER_DAMAGE: begin
            if (on && lay_vis[li])
               clip_to_band(li, x + lay_left[li], y + lay_top[li],
                            x + wi - 1 + lay_left[li], y + hi - 1 + lay_top[li]);
         end
         REQ_DISPLAY_DAMAGE: begin
            for (int i = 0; i < stack_used(); i++)
               if (lay_vis[i]) clip_to_band(i, x, y, x + wi - 1, y + hi - 1);
         end
         default: begin
            cx = x;
            cy = y;
            if (on) begin
               limx = scr_w - lay_wide[li];
               limy = scr_h - lay_tall[li];
               drag = scr_h - 1 - margin;
               if (cx > 0) cx = 0;
               if (cx < limx) cx = limx;
               if (cy > drag) cy = drag;
               if (cy < limy) cy = limy;
            end
            push_result(KIND_CLAMP, li, 0, 0, 0, 0, cx, cy);
         end
      endcase
      if (step_results > 0) expect_q[expect_q.size()-1].last = 1'b1;
   endfunction

   task automatic report_mismatch(string what, int got, int want);
      $display("mismatch %s: got %0d expected %0d", what, got, want);
      errors++;
   endtask

   // result checker
   always @(posedge clock) begin
      res_type e;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (expect_q.size() == 0) begin
            report_mismatch("unexpected result kind", rsp_bus.kind, -1);
         end else begin
            e = expect_q.pop_front();
            if (rsp_bus.kind != e.kind) report_mismatch("kind", rsp_bus.kind, e.kind);
            if (rsp_bus.out_layer != e.out_layer)
               report_mismatch("out_layer", rsp_bus.out_layer, e.out_layer);
            if (rsp_bus.min_x != e.min_x) report_mismatch("min_x", rsp_bus.min_x, e.min_x);
            if (rsp_bus.min_y != e.min_y) report_mismatch("min_y", rsp_bus.min_y, e.min_y);
            if (rsp_bus.max_x != e.max_x) report_mismatch("max_x", rsp_bus.max_x, e.max_x);
            if (rsp_bus.max_y != e.max_y) report_mismatch("max_y", rsp_bus.max_y, e.max_y);
            if (rsp_bus.clamped_x != e.clamped_x)
               report_mismatch("clamped_x", rsp_bus.clamped_x, e.clamped_x);
            if (rsp_bus.clamped_y != e.clamped_y)
               report_mismatch("clamped_y", rsp_bus.clamped_y, e.clamped_y);
            if (rsp_bus.last != e.last) report_mismatch("last", rsp_bus.last, e.last);
         end
      end
   end

   // receiver: random stall pattern, plus one long hold-off on demand
   initial begin
      int mode, stretch;
      stretch       = 0;
      mode          = 0;
      hold_left     = 0;
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_req) begin
            hold_req  = 1'b0;
            hold_left = 150;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_bus.ready = 1'b0;
         end else begin
            if (stretch == 0) begin
               mode    = $urandom_range(0, 2);
               stretch = $urandom_range(10, 60);
            end
            stretch--;
            case (mode)
               0:       rsp_bus.ready = 1'b1;
               1:       rsp_bus.ready = $urandom_range(0, 1);
               default: rsp_bus.ready = ($urandom_range(0, 3) == 0);
            endcase
         end
      end
   end

   // send one request in bursts with random gaps
   task automatic send_request(logic [1:0] rt, logic [2:0] ly, int px, int py, int w, int h);
      req_bus.valid    = 1'b1;
      req_bus.req_type = rt;
      req_bus.layer    = ly;
      req_bus.pos_x    = 16'(px);
      req_bus.pos_y    = 16'(py);
      req_bus.size_w   = 14'(w);
      req_bus.size_h   = 14'(h);
      do @(posedge clock); while (!req_bus.ready);
      predict_request(rt, ly, 16'(px), 16'(py), 14'(w), 14'(h));
      @(negedge clock);
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         req_bus.valid = 1'b0;
         repeat ($urandom_range(1, 6)) @(negedge clock);
         burst_left = $urandom_range(0, 12);
      end
   endtask

   // wait until every request has been answered and the block is idle
   task automatic drain();
      req_bus.valid = 1'b0;
      burst_left    = 0;
      while (expect_q.size() != 0) @(negedge clock);
      repeat (40) @(negedge clock);
   endtask

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, int value);
      csr_we    = 1'b1;
      csr_index = idx;
      csr_wdata = CSR_DATA_W'(value);
      @(negedge clock);
      csr_we = 1'b0;
      case (idx)
         CSR_SCREEN_WIDTH:  scr_w = value & 16'h3FFF;
         CSR_SCREEN_HEIGHT: scr_h = value & 16'h3FFF;
         CSR_LAYER_COUNT: begin
            lay_cnt = value & 4'hF;
            lay_vis = '{default: 1'b0};
         end
         default:           margin = value & 8'hFF;
      endcase
   endtask

   task automatic set_screen(int w, int h, int cnt, int mg);
      drain();
      write_reg(CSR_SCREEN_WIDTH, w);
      write_reg(CSR_SCREEN_HEIGHT, h);
      write_reg(CSR_DRAG_MARGIN, mg);
      write_reg(CSR_LAYER_COUNT, cnt);
   endtask

   // one random request, mostly well formed for the current stack
   task automatic random_request();
      int ly, px, py, w, h;
      if (lay_cnt > 0 && $urandom_range(0, 99) < 85) ly = $urandom_range(0, stack_used() - 1);
      else ly = $urandom_range(0, 7);
      if ($urandom_range(0, 99) < 80) begin
         px = $urandom_range(0, scr_w + 128) - 64;
         py = $urandom_range(0, scr_h + 128) - 64;
      end else begin
         px = $signed(16'($urandom));
         py = $signed(16'($urandom));
      end
      if ($urandom_range(0, 99) < 85) begin
         w = $urandom_range(0, 300);
         h = $urandom_range(0, 300);
      end else begin
         w = $urandom_range(0, 8192);
         h = $urandom_range(0, 8192);
      end
      send_request(2'($urandom_range(0, 3)), 3'(ly), px, py, w, h);
   endtask

   // reset values: empty stack
   task automatic test_reset_state();
      send_request(REQ_VALIDATE, 0, -32768, 32767, 10, 10);
      send_request(REQ_DISPLAY_DAMAGE, 0, 0, 0, 640, 480);
      send_request(REQ_GEOMETRY, 0, 0, 0, 640, 480);
      send_request(REQ_LAYER_DAMAGE, 0, 0, 0, 5, 5);
   endtask

   // layer geometry, overlaps, hidden and off-stack layers
   task automatic test_geometry();
      set_screen(640, 480, 3, 14);
      send_request(REQ_GEOMETRY, 0, 10, 100, 200, 50);
      send_request(REQ_GEOMETRY, 1, -32768, -10, 8192, 300);
      send_request(REQ_GEOMETRY, 2, 0, 400, 640, 480);
      send_request(REQ_GEOMETRY, 2, 32767, 600, 0, 8192);
      send_request(REQ_GEOMETRY, 5, 0, 0, 10, 10);
   endtask

   // layer and display damage
   task automatic test_damage();
      send_request(REQ_LAYER_DAMAGE, 0, 0, 0, 5, 5);
      send_request(REQ_LAYER_DAMAGE, 1, 3, 3, 0, 20);
      send_request(REQ_LAYER_DAMAGE, 2, 0, 0, 50, 50);
      send_request(REQ_DISPLAY_DAMAGE, 7, -32768, -32768, 8192, 8192);
      send_request(REQ_DISPLAY_DAMAGE, 0, 32767, 32767, 8192, 8192);
   endtask

   // position clamping
   task automatic test_validate();
      send_request(REQ_VALIDATE, 0, 100, -100, 0, 0);
      send_request(REQ_VALIDATE, 1, -32768, 32767, 0, 0);
      send_request(REQ_VALIDATE, 7, 32767, -32768, 0, 0);
   endtask

   // zero-sized screen and the full stack at the top extremes
   task automatic test_extremes();
      set_screen(0, 0, 1, 0);
      send_request(REQ_GEOMETRY, 0, 0, 0, 10, 10);
      send_request(REQ_DISPLAY_DAMAGE, 0, 0, 0, 10, 10);
      set_screen(8192, 8192, 8, 255);
      for (int i = 0; i < 8; i++)
         send_request(REQ_GEOMETRY, 3'(7 - i), 0, 1000 * i, 8192, 8192);
      send_request(REQ_VALIDATE, 4, 5, 8000, 0, 0);
   endtask

   // random phases over several settings
   task automatic test_random();
      for (int p = 0; p < 6; p++) begin
         case (p)
            0:       set_screen(640, 480, 8, 14);
            1:       set_screen(1, 1, 1, 0);
            2:       set_screen(8192, 8192, 8, 255);
            default: set_screen($urandom_range(1, 2000), $urandom_range(1, 2000),
                                $urandom_range(0, 8), $urandom_range(0, 255));
         endcase
         for (int n = 0; n < 75; n++) random_request();
      end
   endtask

   // long receiver hold-off while requests keep coming
   task automatic test_pressure();
      set_screen(800, 600, 8, 20);
      hold_req = 1'b1;
      for (int n = 0; n < 30; n++) random_request();
   endtask

   initial begin
      errors           = 0;
      burst_left       = 0;
      hold_req         = 1'b0;
      reset            = 1'b1;
      csr_we           = 1'b0;
      csr_index        = CSR_SCREEN_WIDTH;
      csr_wdata        = '0;
      req_bus.valid    = 1'b0;
      req_bus.req_type = REQ_GEOMETRY;
      req_bus.layer    = '0;
      req_bus.pos_x    = '0;
      req_bus.pos_y    = '0;
      req_bus.size_w   = '0;
      req_bus.size_h   = '0;
      scr_w            = 640;
      scr_h            = 480;
      lay_cnt          = 0;
      margin           = 14;
      lay_left         = '{default: 0};
      lay_top          = '{default: 0};
      lay_wide         = '{default: 0};
      lay_tall         = '{default: 0};
      lay_vis          = '{default: 1'b0};
      band_top         = '{default: 0};
      band_bot         = '{default: 0};
      revealed         = 0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_reset_state();
      test_geometry();
      test_damage();
      test_validate();
      test_extremes();
      test_random();
      test_pressure();
      drain();

      if (errors == 0) $display("PASS screen_stack_clip_engine_top");
      else $display("FAIL screen_stack_clip_engine_top");
      $finish;
   end

endmodule
`default_nettype wire
